// ===== rtl/swdh_pkg.sv =====
`default_nettype none

package swdh_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned DATA_BITS_DEF = 32;

	localparam logic [2:0] ACK_OK = 3'b001;
	localparam logic [2:0] ACK_WAIT = 3'b010;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_REQ   = 4'd1,
		PH_TRN1  = 4'd2,
		PH_ACK   = 4'd3,
		PH_TRN2  = 4'd4,
		PH_WDATA = 4'd5,
		PH_WPAR  = 4'd6,
		PH_RDATA = 4'd7,
		PH_RTAIL = 4'd8,
		PH_WAITX = 4'd9
	} phase_t;

	typedef struct packed {
		logic              cmd;
		logic              ap_ndp;
		logic              rnw;
		logic [1:0]        reg_addr;
		logic [WORD_W-1:0] write_data;
		logic              swdio_in;
	} req_t;

	typedef struct packed {
		logic              swdio_out;
		logic              swdio_oe;
		logic              clock_active;
		logic              busy_res;
		logic              done_res;
		logic [2:0]        ack;
		logic [WORD_W-1:0] rd_word;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/swd_host_transaction_core.sv =====
`default_nettype none

// channel  | valid      | stall      | payload
// request  | req_valid  | req_stall  | req (swdh_pkg::req_t)
// response | rsp_valid  | rsp_stall  | rsp (swdh_pkg::rsp_t)
//
// every request gives one response, registered when it is taken and valid in the next cycle
// one request per cycle while req_stall is low; each request is one SWCLK period of the transaction
// a request is taken while the response register is empty or being emptied
// rsp_stall holds the response register and, through req_stall, the state
// arst_n clears the transaction state and empties the response register

module swd_host_transaction_core #(
	parameter int unsigned DATA_BITS = swdh_pkg::DATA_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire swdh_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output swdh_pkg::rsp_t      rsp
);

	localparam int unsigned CNT_W = $clog2(DATA_BITS + 1);

	swdh_pkg::phase_t     phase_q, phase_d;
	logic [CNT_W-1:0]     bit_count_q, bit_count_d;
	logic [DATA_BITS-1:0] shift_q, shift_d;
	logic [7:0]           request_byte_q, request_byte_d;
	logic [2:0]           ack_q, ack_d;
	logic                 is_read_q, is_read_d;
	logic                 is_ap_q, is_ap_d;
	logic                 data_parity_q, data_parity_d;

	logic                 rsp_valid_q;
	swdh_pkg::rsp_t       rsp_q, rsp_d;
	logic                 take;

	logic                 o_out, o_oe, o_clk, o_done, finish;
	logic [DATA_BITS-1:0] o_rd;
	logic [2:0]           ack_acc;
	logic                 a2, a3;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign take = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign a2 = req.reg_addr[0];
	assign a3 = req.reg_addr[1];
	assign ack_acc = ack_q | (3'(req.swdio_in) << bit_count_q[1:0]);

	always_comb begin
		phase_d = phase_q;
		bit_count_d = bit_count_q;
		shift_d = shift_q;
		request_byte_d = request_byte_q;
		ack_d = ack_q;
		is_read_d = is_read_q;
		is_ap_d = is_ap_q;
		data_parity_d = data_parity_q;
		o_out = 1'b1;
		o_oe = 1'b1;
		o_clk = 1'b1;
		o_rd = '0;
		finish = 1'b0;

		unique case (phase_q)
			swdh_pkg::PH_REQ: begin
				o_out = request_byte_q[3'd7 - bit_count_q[2:0]];
				bit_count_d = bit_count_q + CNT_W'(1);
				if (bit_count_q[2:0] == 3'd7) begin
					phase_d = swdh_pkg::PH_TRN1;
					bit_count_d = '0;
				end
			end
			swdh_pkg::PH_TRN1: begin
				o_oe = 1'b0;
				phase_d = swdh_pkg::PH_ACK;
				bit_count_d = '0;
			end
			swdh_pkg::PH_ACK: begin
				o_oe = 1'b0;
				ack_d = ack_acc;
				bit_count_d = bit_count_q + CNT_W'(1);
				if (bit_count_q == CNT_W'(2)) begin
					bit_count_d = '0;
					if (ack_acc == swdh_pkg::ACK_OK) begin
						if (is_read_q) begin
							phase_d = swdh_pkg::PH_RDATA;
							shift_d = '0;
						end else begin
							phase_d = swdh_pkg::PH_TRN2;
						end
					end else if (ack_acc == swdh_pkg::ACK_WAIT && is_ap_q && is_read_q) begin
						phase_d = swdh_pkg::PH_WAITX;
					end else begin
						finish = 1'b1;
					end
				end
			end
			swdh_pkg::PH_TRN2: begin
				o_oe = 1'b0;
				phase_d = swdh_pkg::PH_WDATA;
				bit_count_d = '0;
			end
			swdh_pkg::PH_WDATA: begin
				o_out = shift_q[0];
				shift_d = shift_q >> 1;
				bit_count_d = bit_count_q + CNT_W'(1);
				if (bit_count_q == CNT_W'(DATA_BITS - 1)) begin
					phase_d = swdh_pkg::PH_WPAR;
					bit_count_d = '0;
				end
			end
			swdh_pkg::PH_WPAR: begin
				o_out = data_parity_q;
				finish = 1'b1;
			end
			swdh_pkg::PH_RDATA: begin
				o_oe = 1'b0;
				// lsb first: shift in at the top
				shift_d = {req.swdio_in, shift_q[DATA_BITS-1:1]};
				bit_count_d = bit_count_q + CNT_W'(1);
				if (bit_count_q == CNT_W'(DATA_BITS - 1)) begin
					phase_d = swdh_pkg::PH_RTAIL;
					bit_count_d = '0;
				end
			end
			swdh_pkg::PH_RTAIL: begin
				o_oe = 1'b0;
				bit_count_d = bit_count_q + CNT_W'(1);
				if (bit_count_q != '0) begin
					finish = 1'b1;
					o_rd = shift_q;
				end
			end
			swdh_pkg::PH_WAITX: begin
				o_oe = 1'b0;
				finish = 1'b1;
			end
			default: begin
				// idle, and any undefined phase code
				o_clk = 1'b0;
				phase_d = swdh_pkg::PH_IDLE;
				if (req.cmd == swdh_pkg::CMD_START) begin
					is_ap_d = req.ap_ndp;
					is_read_d = req.rnw;
					request_byte_d = {1'b1, req.ap_ndp, req.rnw, a2, a3,
						req.ap_ndp ^ req.rnw ^ a2 ^ a3, 1'b0, 1'b1};
					shift_d = req.rnw ? '0 : req.write_data[DATA_BITS-1:0];
					data_parity_d = ^req.write_data[DATA_BITS-1:0];
					ack_d = '0;
					bit_count_d = '0;
					phase_d = swdh_pkg::PH_REQ;
				end
			end
		endcase

		if (!o_oe) begin
			o_out = 1'b1;
		end
		o_done = finish;
		if (finish) begin
			phase_d = swdh_pkg::PH_IDLE;
			bit_count_d = '0;
		end

		rsp_d.swdio_out = o_out;
		rsp_d.swdio_oe = o_oe;
		rsp_d.clock_active = o_clk;
		rsp_d.busy_res = (phase_d != swdh_pkg::PH_IDLE);
		rsp_d.done_res = o_done;
		rsp_d.ack = ack_d;
		rsp_d.rd_word = swdh_pkg::WORD_W'(o_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swdh_pkg::PH_IDLE;
			bit_count_q <= '0;
			shift_q <= '0;
			request_byte_q <= '0;
			ack_q <= '0;
			is_read_q <= 1'b0;
			is_ap_q <= 1'b0;
			data_parity_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			bit_count_q <= bit_count_d;
			shift_q <= shift_d;
			request_byte_q <= request_byte_d;
			ack_q <= ack_d;
			is_read_q <= is_read_d;
			is_ap_q <= is_ap_d;
			data_parity_q <= data_parity_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTH
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == swdh_pkg::PH_IDLE |-> bit_count_q == '0)
		else $error("bit count not cleared in idle");

	a_done_clock: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.done_res |-> rsp_q.clock_active && !rsp_q.busy_res)
		else $error("done without clock or while busy");

	a_rd_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.done_res |-> rsp_q.rd_word == '0)
		else $error("read word outside done");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid_q)
		else $error("request stalled with empty response register");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == swdh_pkg::PH_IDLE |=> rsp_q.swdio_oe && !rsp_q.clock_active)
		else $error("idle request issued clock or released line");
`endif

endmodule

`default_nettype wire
